[src/ccrc_pkg.sv]
package ccrc_pkg;

  // largest source or frame dimension accepted by a start
  localparam int unsigned MAX_DIMENSION = 4096;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_GEOM = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

  // input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_BORDER_WIDTH  = 3'd4;
  localparam logic [2:0] REG_CORNER_RADIUS = 3'd5;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_WAIT,
    S_G_CHK0,
    S_G_DIV1,
    S_G_CHK1,
    S_G_MUL2,
    S_G_DIV2,
    S_G_CHK2,
    S_G_FIN,
    S_F_MUL1,
    S_F_DIV1,
    S_F_MUL2,
    S_F_DIV2,
    S_F_MUL3,
    S_F_ADD,
    S_P_COV,
    S_P_SMP,
    S_P_SH0,
    S_P_RD,
    S_P_GM,
    S_P_GD,
    S_P_BM,
    S_P_BD,
    S_P_PACK,
    S_P_TGT,
    S_P_ADV,
    S_OUT
  } state_e;

endpackage

[src/cover_crop_rounded_corner_compositor.sv]
// Centre-crop, nearest-neighbour scale and rounded-corner shading of one frame. A start
// transfer (operation 0) works out the crop from the registers and answers with the index of
// the first source pixel to fetch; each pixel transfer (operation 1) returns the shaded pixel,
// its frame index and the next fetch index. Items are handled one at a time by a sequencer
// around a single bit-serial multiply/divide unit. A pixel at a corner takes longer than one
// inside the image, as its shading needs three multiply/divide pairs after each coverage
// sample (SUBSAMPLES squared samples) is checked in turn. A finished result waits in an
// output register, so the next item is taken while it is still stalled.
module cover_crop_rounded_corner_compositor #(
  parameter int SUBSAMPLES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] source_pixel_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        pixel_valid_o,
  output logic [15:0] out_pixel_o,
  output logic [23:0] target_index_o,
  output logic        fetch_valid_o,
  output logic [23:0] fetch_index_o,
  output logic        frame_done_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int UNITS = 2 * SUBSAMPLES;
  localparam int FULL  = SUBSAMPLES * SUBSAMPLES;
  localparam int HALF  = FULL / 2;
  localparam int COVW  = $clog2(FULL + 1);
  localparam int SIW   = (SUBSAMPLES > 1) ? $clog2(SUBSAMPLES) : 1;
  localparam int CTRW  = $clog2(255 * UNITS + 1);
  localparam int SQW   = 2 * CTRW + 1;
  localparam int AW    = 26;
  localparam int BW    = 13;

  // configuration registers
  logic [12:0] src_w_q, src_h_q, frm_w_q, frm_h_q;
  logic [7:0]  border_q, radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= 13'd1;
      src_h_q  <= 13'd1;
      frm_w_q  <= 13'd1;
      frm_h_q  <= 13'd1;
      border_q <= 8'd0;
      radius_q <= 8'd22;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ccrc_pkg::REG_SOURCE_WIDTH:  src_w_q  <= cfg_data_i;
        ccrc_pkg::REG_SOURCE_HEIGHT: src_h_q  <= cfg_data_i;
        ccrc_pkg::REG_FRAME_WIDTH:   frm_w_q  <= cfg_data_i;
        ccrc_pkg::REG_FRAME_HEIGHT:  frm_h_q  <= cfg_data_i;
        ccrc_pkg::REG_BORDER_WIDTH:  border_q <= cfg_data_i[7:0];
        ccrc_pkg::REG_CORNER_RADIUS: radius_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // bit-serial multiply / restoring divide unit
  logic          eng_go, eng_div;
  logic [AW-1:0] eng_a;
  logic [BW-1:0] eng_b;
  logic          eng_div_q, eng_busy_q, eng_done_q;
  logic [4:0]    eng_cnt_q;
  logic [AW-1:0] eng_a_q, eng_acc_q;
  logic [BW-1:0] eng_b_q;
  logic [BW:0]   eng_rem_q;
  logic [BW:0]   trial;
  logic          trial_ge;
  logic [AW-1:0] eng_res;

  assign trial    = {eng_rem_q[BW-1:0], eng_a_q[AW-1]};
  assign trial_ge = trial >= {1'b0, eng_b_q};
  assign eng_res  = eng_div_q ? eng_a_q : eng_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_div_q  <= 1'b0;
      eng_busy_q <= 1'b0;
      eng_done_q <= 1'b0;
      eng_cnt_q  <= '0;
      eng_a_q    <= '0;
      eng_acc_q  <= '0;
      eng_b_q    <= '0;
      eng_rem_q  <= '0;
    end else begin
      eng_done_q <= eng_busy_q && (eng_cnt_q == 5'd1);
      if (eng_go) begin
        eng_div_q  <= eng_div;
        eng_a_q    <= eng_a;
        eng_b_q    <= eng_b;
        eng_acc_q  <= '0;
        eng_rem_q  <= '0;
        eng_cnt_q  <= eng_div ? 5'(AW) : 5'(BW);
        eng_busy_q <= 1'b1;
      end else if (eng_busy_q) begin
        eng_cnt_q <= eng_cnt_q - 5'd1;
        if (eng_cnt_q == 5'd1) eng_busy_q <= 1'b0;
        if (eng_div_q) begin
          eng_rem_q <= trial_ge ? (trial - {1'b0, eng_b_q}) : trial;
          eng_a_q   <= {eng_a_q[AW-2:0], trial_ge};
        end else begin
          if (eng_b_q[0]) eng_acc_q <= eng_acc_q + eng_a_q;
          eng_a_q <= {eng_a_q[AW-2:0], 1'b0};
          eng_b_q <= {1'b0, eng_b_q[BW-1:1]};
        end
      end
    end
  end

  // frame state and latched geometry
  ccrc_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic            active_q;
  logic [11:0]     col_q, row_q;
  logic [12:0]     crop_w_q, crop_h_q;
  logic [11:0]     crop_l_q, crop_t_q;
  logic [12:0]     lat_src_w_q, lat_iw_q, lat_ih_q, lat_fw_q;
  logic [7:0]      lat_b_q, lat_r_q;
  logic [CTRW-1:0] center_q;
  logic [2*CTRW-1:0] rsq_q;
  logic [12:0]     sy_q, sx_q;
  logic [15:0]     pix_q;
  logic [COVW-1:0] cov_q;
  logic [7:0]      ex_q, ey_q;
  logic [SIW-1:0]  sxc_q, syc_q;
  logic [4:0]      rr_q;
  logic [5:0]      gg_q;

  // working result
  logic [1:0]  wk_status_q;
  logic        wk_pv_q, wk_fv_q, wk_done_q;
  logic [15:0] wk_pix_q;
  logic [23:0] wk_tgt_q, wk_fidx_q;

  // output register
  logic        out_valid_q;

  // geometry check on the live registers
  logic [8:0]  two_b;
  logic [12:0] iw_c, ih_c;
  logic        geo_bad;
  assign two_b = {border_q, 1'b0};
  assign iw_c  = frm_w_q - {4'b0, two_b};
  assign ih_c  = frm_h_q - {4'b0, two_b};
  assign geo_bad = (src_w_q == 13'd0) || (src_h_q == 13'd0) ||
                   (frm_w_q == 13'd0) || (frm_h_q == 13'd0) ||
                   (32'(src_w_q) > ccrc_pkg::MAX_DIMENSION) ||
                   (32'(src_h_q) > ccrc_pkg::MAX_DIMENSION) ||
                   (32'(frm_w_q) > ccrc_pkg::MAX_DIMENSION) ||
                   (32'(frm_h_q) > ccrc_pkg::MAX_DIMENSION) ||
                   (frm_w_q <= {4'b0, two_b}) || (frm_h_q <= {4'b0, two_b});

  // corner region test for the current pixel
  logic [12:0] col_w, row_w, two_r;
  logic        cov_full, in_left, in_top, corner_x, corner_y;
  logic [12:0] ex_c, ey_c;
  assign col_w    = {1'b0, col_q};
  assign row_w    = {1'b0, row_q};
  assign two_r    = {4'b0, lat_r_q, 1'b0};
  assign in_left  = col_w < {5'b0, lat_r_q};
  assign in_top   = row_w < {5'b0, lat_r_q};
  assign corner_x = in_left || (col_w >= (lat_iw_q - {5'b0, lat_r_q}));
  assign corner_y = in_top || (row_w >= (lat_ih_q - {5'b0, lat_r_q}));
  assign cov_full = (lat_r_q == 8'd0) || (lat_iw_q < two_r) || (lat_ih_q < two_r) ||
                    !corner_x || !corner_y;
  assign ex_c     = in_left ? col_w : (lat_iw_q - 13'd1 - col_w);
  assign ey_c     = in_top ? row_w : (lat_ih_q - 13'd1 - row_w);

  // one coverage sample against the radius
  logic [CTRW-1:0] off_x, off_y, dx, dy;
  logic [SQW-1:0]  dist_sq;
  logic            hit, smp_last;
  assign off_x    = CTRW'(ex_q) * CTRW'(UNITS) + CTRW'({sxc_q, 1'b1});
  assign off_y    = CTRW'(ey_q) * CTRW'(UNITS) + CTRW'({syc_q, 1'b1});
  assign dx       = center_q - off_x;
  assign dy       = center_q - off_y;
  assign dist_sq  = SQW'(dx) * SQW'(dx) + SQW'(dy) * SQW'(dy);
  assign hit      = dist_sq <= SQW'(rsq_q);
  assign smp_last = (sxc_q == SIW'(SUBSAMPLES - 1)) && (syc_q == SIW'(SUBSAMPLES - 1));

  // raster advance
  logic [12:0] col_n, row_n;
  logic        wrap_col, adv_done;
  assign col_n    = col_w + 13'd1;
  assign row_n    = row_w + 13'd1;
  assign wrap_col = col_n >= lat_iw_q;
  assign adv_done = wrap_col && (row_n >= lat_ih_q);

  // source pixel channels
  logic [15:0] pix_c;
  logic [15:0] packed_c;
  assign pix_c    = {pix_q[7:0], pix_q[15:8]};
  assign packed_c = {rr_q, gg_q, eng_res[4:0]};

  logic out_free;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ccrc_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccrc_pkg::S_IDLE;
      ret_q   <= ccrc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // next state and unit requests
  always_comb begin
    ccrc_pkg::state_e nxt;
    nxt     = state_q;
    ret_d   = ret_q;
    eng_go  = 1'b0;
    eng_div = 1'b0;
    eng_a   = '0;
    eng_b   = '0;
    unique case (state_q)
      ccrc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == ccrc_pkg::OP_START) nxt = ccrc_pkg::S_G_CHK0;
          else if (!active_q)                    nxt = ccrc_pkg::S_OUT;
          else                                   nxt = ccrc_pkg::S_P_COV;
        end
      end
      ccrc_pkg::S_WAIT: begin
        if (eng_done_q) nxt = ret_q;
      end
      ccrc_pkg::S_G_CHK0: begin
        if (geo_bad) begin
          nxt = ccrc_pkg::S_OUT;
        end else begin
          eng_go = 1'b1;
          eng_a  = AW'(src_w_q);
          eng_b  = ih_c;
          nxt    = ccrc_pkg::S_G_DIV1;
        end
      end
      ccrc_pkg::S_G_DIV1: begin
        eng_go  = 1'b1;
        eng_div = 1'b1;
        eng_a   = eng_res;
        eng_b   = lat_iw_q;
        nxt     = ccrc_pkg::S_G_CHK1;
      end
      ccrc_pkg::S_G_CHK1: begin
        if ((eng_res > AW'(src_h_q)) || (eng_res == '0)) nxt = ccrc_pkg::S_G_MUL2;
        else                                            nxt = ccrc_pkg::S_G_FIN;
      end
      ccrc_pkg::S_G_MUL2: begin
        eng_go = 1'b1;
        eng_a  = AW'(src_h_q);
        eng_b  = lat_iw_q;
        nxt    = ccrc_pkg::S_G_DIV2;
      end
      ccrc_pkg::S_G_DIV2: begin
        eng_go  = 1'b1;
        eng_div = 1'b1;
        eng_a   = eng_res;
        eng_b   = lat_ih_q;
        nxt     = ccrc_pkg::S_G_CHK2;
      end
      ccrc_pkg::S_G_CHK2: nxt = ccrc_pkg::S_G_FIN;
      ccrc_pkg::S_G_FIN: begin
        if ((crop_w_q == 13'd0) || (crop_h_q == 13'd0)) nxt = ccrc_pkg::S_OUT;
        else                                            nxt = ccrc_pkg::S_F_MUL1;
      end
      ccrc_pkg::S_F_MUL1: begin
        eng_go = 1'b1;
        eng_a  = AW'(row_q);
        eng_b  = crop_h_q;
        nxt    = ccrc_pkg::S_F_DIV1;
      end
      ccrc_pkg::S_F_DIV1: begin
        eng_go  = 1'b1;
        eng_div = 1'b1;
        eng_a   = eng_res;
        eng_b   = lat_ih_q;
        nxt     = ccrc_pkg::S_F_MUL2;
      end
      ccrc_pkg::S_F_MUL2: begin
        eng_go = 1'b1;
        eng_a  = AW'(col_q);
        eng_b  = crop_w_q;
        nxt    = ccrc_pkg::S_F_DIV2;
      end
      ccrc_pkg::S_F_DIV2: begin
        eng_go  = 1'b1;
        eng_div = 1'b1;
        eng_a   = eng_res;
        eng_b   = lat_iw_q;
        nxt     = ccrc_pkg::S_F_MUL3;
      end
      ccrc_pkg::S_F_MUL3: begin
        eng_go = 1'b1;
        eng_a  = AW'(sy_q);
        eng_b  = lat_src_w_q;
        nxt    = ccrc_pkg::S_F_ADD;
      end
      ccrc_pkg::S_F_ADD: nxt = ccrc_pkg::S_OUT;
      ccrc_pkg::S_P_COV: begin
        nxt = cov_full ? ccrc_pkg::S_P_SH0 : ccrc_pkg::S_P_SMP;
      end
      ccrc_pkg::S_P_SMP: begin
        if (smp_last) nxt = ccrc_pkg::S_P_SH0;
      end
      ccrc_pkg::S_P_SH0: begin
        if ((cov_q == '0) || (32'(cov_q) >= FULL)) begin
          nxt = ccrc_pkg::S_P_TGT;
        end else begin
          eng_go = 1'b1;
          eng_a  = AW'(pix_c[15:11]);
          eng_b  = BW'(cov_q);
          nxt    = ccrc_pkg::S_P_RD;
        end
      end
      ccrc_pkg::S_P_RD, ccrc_pkg::S_P_GD, ccrc_pkg::S_P_BD: begin
        eng_go  = 1'b1;
        eng_div = 1'b1;
        eng_a   = eng_res + AW'(HALF);
        eng_b   = BW'(FULL);
        priority case (state_q)
          ccrc_pkg::S_P_RD: nxt = ccrc_pkg::S_P_GM;
          ccrc_pkg::S_P_GD: nxt = ccrc_pkg::S_P_BM;
          default:          nxt = ccrc_pkg::S_P_PACK;
        endcase
      end
      ccrc_pkg::S_P_GM: begin
        eng_go = 1'b1;
        eng_a  = AW'(pix_c[10:5]);
        eng_b  = BW'(cov_q);
        nxt    = ccrc_pkg::S_P_GD;
      end
      ccrc_pkg::S_P_BM: begin
        eng_go = 1'b1;
        eng_a  = AW'(pix_c[4:0]);
        eng_b  = BW'(cov_q);
        nxt    = ccrc_pkg::S_P_BD;
      end
      ccrc_pkg::S_P_PACK: nxt = ccrc_pkg::S_P_TGT;
      ccrc_pkg::S_P_TGT: begin
        eng_go = 1'b1;
        eng_a  = AW'(row_w + {5'b0, lat_b_q});
        eng_b  = lat_fw_q;
        nxt    = ccrc_pkg::S_P_ADV;
      end
      ccrc_pkg::S_P_ADV: begin
        nxt = adv_done ? ccrc_pkg::S_OUT : ccrc_pkg::S_F_MUL1;
      end
      ccrc_pkg::S_OUT: begin
        if (out_free) nxt = ccrc_pkg::S_IDLE;
      end
      default: nxt = ccrc_pkg::S_IDLE;
    endcase
    if (eng_go) begin
      ret_d   = nxt;
      state_d = ccrc_pkg::S_WAIT;
    end else begin
      state_d = nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      crop_w_q    <= '0;
      crop_h_q    <= '0;
      crop_l_q    <= '0;
      crop_t_q    <= '0;
      lat_src_w_q <= '0;
      lat_iw_q    <= '0;
      lat_ih_q    <= '0;
      lat_fw_q    <= '0;
      lat_b_q     <= '0;
      lat_r_q     <= '0;
      center_q    <= '0;
      rsq_q       <= '0;
      sy_q        <= '0;
      sx_q        <= '0;
      pix_q       <= '0;
      cov_q       <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      sxc_q       <= '0;
      syc_q       <= '0;
      rr_q        <= '0;
      gg_q        <= '0;
      wk_status_q <= ccrc_pkg::STATUS_OK;
      wk_pv_q     <= 1'b0;
      wk_fv_q     <= 1'b0;
      wk_done_q   <= 1'b0;
      wk_pix_q    <= '0;
      wk_tgt_q    <= '0;
      wk_fidx_q   <= '0;
    end else begin
      unique case (state_q)
        ccrc_pkg::S_IDLE: begin
          if (in_valid_i) begin
            pix_q       <= source_pixel_i;
            wk_status_q <= ccrc_pkg::STATUS_OK;
            wk_pv_q     <= 1'b0;
            wk_fv_q     <= 1'b0;
            wk_done_q   <= 1'b0;
            wk_pix_q    <= '0;
            wk_tgt_q    <= '0;
            wk_fidx_q   <= '0;
            if (operation_i == ccrc_pkg::OP_START) active_q <= 1'b0;
            else if (!active_q) wk_status_q <= ccrc_pkg::STATUS_NO_FRAME;
          end
        end
        ccrc_pkg::S_G_CHK0: begin
          if (geo_bad) begin
            wk_status_q <= ccrc_pkg::STATUS_BAD_GEOM;
          end else begin
            lat_src_w_q <= src_w_q;
            lat_iw_q    <= iw_c;
            lat_ih_q    <= ih_c;
            lat_fw_q    <= frm_w_q;
            lat_b_q     <= border_q;
            lat_r_q     <= radius_q;
            center_q    <= CTRW'(radius_q) * CTRW'(UNITS);
          end
        end
        ccrc_pkg::S_G_DIV1: rsq_q <= center_q * center_q;
        ccrc_pkg::S_G_CHK1: begin
          crop_h_q <= eng_res[12:0];
          crop_w_q <= src_w_q;
        end
        ccrc_pkg::S_G_MUL2: crop_h_q <= src_h_q;
        ccrc_pkg::S_G_CHK2: begin
          crop_w_q <= (eng_res > AW'(src_w_q)) ? src_w_q : eng_res[12:0];
        end
        ccrc_pkg::S_G_FIN: begin
          if ((crop_w_q == 13'd0) || (crop_h_q == 13'd0)) begin
            wk_status_q <= ccrc_pkg::STATUS_BAD_GEOM;
          end else begin
            crop_l_q <= 12'((src_w_q - crop_w_q) >> 1);
            crop_t_q <= 12'((src_h_q - crop_h_q) >> 1);
            col_q    <= '0;
            row_q    <= '0;
            active_q <= 1'b1;
          end
        end
        ccrc_pkg::S_F_MUL2: sy_q <= eng_res[12:0] + {1'b0, crop_t_q};
        ccrc_pkg::S_F_MUL3: sx_q <= eng_res[12:0] + {1'b0, crop_l_q};
        ccrc_pkg::S_F_ADD: begin
          wk_fv_q   <= 1'b1;
          wk_fidx_q <= eng_res[23:0] + 24'(sx_q);
        end
        ccrc_pkg::S_P_COV: begin
          if (cov_full) begin
            cov_q <= COVW'(FULL);
          end else begin
            cov_q <= '0;
            ex_q  <= ex_c[7:0];
            ey_q  <= ey_c[7:0];
            sxc_q <= '0;
            syc_q <= '0;
          end
        end
        ccrc_pkg::S_P_SMP: begin
          cov_q <= cov_q + COVW'(hit);
          if (sxc_q == SIW'(SUBSAMPLES - 1)) begin
            sxc_q <= '0;
            syc_q <= syc_q + SIW'(1);
          end else begin
            sxc_q <= sxc_q + SIW'(1);
          end
        end
        ccrc_pkg::S_P_SH0: begin
          if (cov_q == '0) wk_pix_q <= '0;
          else if (32'(cov_q) >= FULL) wk_pix_q <= pix_q;
        end
        ccrc_pkg::S_P_GM: rr_q <= eng_res[4:0];
        ccrc_pkg::S_P_BM: gg_q <= eng_res[5:0];
        ccrc_pkg::S_P_PACK: wk_pix_q <= {packed_c[7:0], packed_c[15:8]};
        ccrc_pkg::S_P_TGT: wk_pv_q <= 1'b1;
        ccrc_pkg::S_P_ADV: begin
          wk_tgt_q <= eng_res[23:0] + 24'(col_q) + 24'(lat_b_q);
          if (adv_done) begin
            col_q     <= '0;
            row_q     <= '0;
            active_q  <= 1'b0;
            wk_done_q <= 1'b1;
          end else if (wrap_col) begin
            col_q <= '0;
            row_q <= row_n[11:0];
          end else begin
            col_q <= col_n[11:0];
          end
        end
        default: ;
      endcase
    end
  end

  // result register, loaded when the sequencer finishes an item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      status_o       <= ccrc_pkg::STATUS_OK;
      pixel_valid_o  <= 1'b0;
      out_pixel_o    <= '0;
      target_index_o <= '0;
      fetch_valid_o  <= 1'b0;
      fetch_index_o  <= '0;
      frame_done_o   <= 1'b0;
    end else begin
      if ((state_q == ccrc_pkg::S_OUT) && out_free) begin
        out_valid_q    <= 1'b1;
        status_o       <= wk_status_q;
        pixel_valid_o  <= wk_pv_q;
        out_pixel_o    <= wk_pix_q;
        target_index_o <= wk_tgt_q;
        fetch_valid_o  <= wk_fv_q;
        fetch_index_o  <= wk_fidx_q;
        frame_done_o   <= wk_done_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/ccrc_checker.sv]
module ccrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        pixel_valid_o,
  input logic [15:0] out_pixel_o,
  input logic [23:0] target_index_o,
  input logic        fetch_valid_o,
  input logic [23:0] fetch_index_o,
  input logic        frame_done_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // no pixel means zeroed pixel fields
  a_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |-> (out_pixel_o == 16'd0) && (target_index_o == 24'd0))
    else $error("pixel fields set without a pixel");

  // no fetch means zero fetch index
  a_fetch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fetch_valid_o |-> fetch_index_o == 24'd0)
    else $error("fetch index set without a fetch");

  // last pixel of a frame carries a pixel and asks for nothing more
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |->
      pixel_valid_o && !fetch_valid_o && (status_o == ccrc_pkg::STATUS_OK))
    else $error("frame done on a result that is not the last pixel");

endmodule

bind cover_crop_rounded_corner_compositor ccrc_checker u_ccrc_checker (.*);

[sim/ccrc_result_checker.sv]
module ccrc_result_checker
  import ccrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [15:0] source_pixel_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic        pixel_valid_i,
  input  logic [15:0] out_pixel_i,
  input  logic [23:0] target_index_i,
  input  logic        fetch_valid_i,
  input  logic [23:0] fetch_index_i,
  input  logic        frame_done_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  output int          fail_count_o,
  output int          awaited_count_o
);

  localparam int unsigned SAMPLES = 4;
  localparam int unsigned FULL_COV = SAMPLES * SAMPLES;

  typedef struct packed {
    logic [1:0]  status;
    logic        pixel_valid;
    logic [15:0] out_pixel;
    logic [23:0] target_index;
    logic        fetch_valid;
    logic [23:0] fetch_index;
    logic        frame_done;
  } frame_result_t;

  frame_result_t awaited_results[$];

  // register copies, taken from the configuration transfers
  logic [12:0] src_w, src_h, frm_w, frm_h;
  logic [7:0]  border, radius;

  // walk state and values latched on a good start
  logic        active;
  int unsigned col, row;
  int unsigned crop_w, crop_h, crop_l, crop_t;
  int unsigned lt_src_w, lt_img_w, lt_img_h, lt_frm_w, lt_border, lt_radius;

  assign awaited_count_o = awaited_results.size();

  // number of corner subsamples inside the rounded edge
  function automatic int unsigned corner_coverage(int unsigned x, int unsigned y);
    longint ex, ey, ctr, rsq, dx, dy;
    int unsigned cnt;
    logic at_l, at_r, at_t, at_b;
    cnt = 0;
    if (lt_radius == 0 || lt_img_w < 2 * lt_radius || lt_img_h < 2 * lt_radius)
      return FULL_COV;
    at_l = x < lt_radius;
    at_r = x >= lt_img_w - lt_radius;
    at_t = y < lt_radius;
    at_b = y >= lt_img_h - lt_radius;
    if ((!at_l && !at_r) || (!at_t && !at_b)) return FULL_COV;
    ex = at_l ? longint'(x) : longint'(lt_img_w - 1 - x);
    ey = at_t ? longint'(y) : longint'(lt_img_h - 1 - y);
    ctr = longint'(lt_radius) * SAMPLES * 2;
    rsq = ctr * ctr;
    for (int sy = 0; sy < SAMPLES; sy++) begin
      dy = ctr - (ey * SAMPLES * 2 + sy * 2 + 1);
      for (int sx = 0; sx < SAMPLES; sx++) begin
        dx = ctr - (ex * SAMPLES * 2 + sx * 2 + 1);
        if (dx * dx + dy * dy <= rsq) cnt++;
      end
    end
    return cnt;
  endfunction

  // blend a byte-swapped rgb565 pixel toward black
  function automatic logic [15:0] darken(logic [15:0] swp, int unsigned cov);
    logic [15:0] c, b;
    int unsigned rr, gg, bb;
    if (cov == 0) return 16'h0000;
    if (cov >= FULL_COV) return swp;
    c = {swp[7:0], swp[15:8]};
    rr = (int'(c[15:11]) * cov + FULL_COV / 2) / FULL_COV;
    gg = (int'(c[10:5]) * cov + FULL_COV / 2) / FULL_COV;
    bb = (int'(c[4:0]) * cov + FULL_COV / 2) / FULL_COV;
    b = {rr[4:0], gg[5:0], bb[4:0]};
    return {b[7:0], b[15:8]};
  endfunction

  function automatic logic [23:0] source_index(int unsigned x, int unsigned y);
    longint unsigned sy, sx;
    sy = crop_t + (longint'(y) * crop_h) / lt_img_h;
    sx = crop_l + (longint'(x) * crop_w) / lt_img_w;
    return 24'(sy * lt_src_w + sx);
  endfunction

  // expected result of one input transfer, advancing the walk state
  function automatic frame_result_t predict_item(logic op, logic [15:0] pix);
    frame_result_t r;
    longint unsigned cw, ch, iw, ih;
    r = '0;
    if (op == OP_START) begin
      active = 1'b0;
      if (src_w == 0 || src_h == 0 || frm_w == 0 || frm_h == 0 ||
          src_w > MAX_DIMENSION || src_h > MAX_DIMENSION ||
          frm_w > MAX_DIMENSION || frm_h > MAX_DIMENSION ||
          frm_w <= 2 * border || frm_h <= 2 * border) begin
        r.status = STATUS_BAD_GEOM;
        return r;
      end
      iw = frm_w - 2 * border;
      ih = frm_h - 2 * border;
      cw = src_w;
      ch = (cw * ih) / iw;
      if (ch > src_h || ch == 0) begin
        ch = src_h;
        cw = (ch * iw) / ih;
        if (cw > src_w) cw = src_w;
      end
      if (cw == 0 || ch == 0) begin
        r.status = STATUS_BAD_GEOM;
        return r;
      end
      crop_w = cw;
      crop_h = ch;
      crop_l = (src_w - cw) / 2;
      crop_t = (src_h - ch) / 2;
      lt_src_w = src_w;
      lt_img_w = iw;
      lt_img_h = ih;
      lt_frm_w = frm_w;
      lt_border = border;
      lt_radius = radius;
      col = 0;
      row = 0;
      active = 1'b1;
      r.fetch_valid = 1'b1;
      r.fetch_index = source_index(0, 0);
      return r;
    end
    if (!active) begin
      r.status = STATUS_NO_FRAME;
      return r;
    end
    r.pixel_valid = 1'b1;
    r.out_pixel = darken(pix, corner_coverage(col, row));
    r.target_index = 24'((longint'(row) + lt_border) * lt_frm_w + col + lt_border);
    col++;
    if (col >= lt_img_w) begin
      col = 0;
      row++;
    end
    if (row >= lt_img_h) begin
      row = 0;
      col = 0;
      active = 1'b0;
      r.frame_done = 1'b1;
    end else begin
      r.fetch_valid = 1'b1;
      r.fetch_index = source_index(col, row);
    end
    return r;
  endfunction

  function automatic void compare_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t e;
    if (!rst_ni) begin
      src_w = 13'd1; src_h = 13'd1; frm_w = 13'd1; frm_h = 13'd1;
      border = 8'd0; radius = 8'd22;
      active = 1'b0; col = 0; row = 0;
      crop_w = 0; crop_h = 0; crop_l = 0; crop_t = 0;
      lt_src_w = 0; lt_img_w = 0; lt_img_h = 0;
      lt_frm_w = 0; lt_border = 0; lt_radius = 0;
      awaited_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SOURCE_WIDTH:  src_w = cfg_data_i;
          REG_SOURCE_HEIGHT: src_h = cfg_data_i;
          REG_FRAME_WIDTH:   frm_w = cfg_data_i;
          REG_FRAME_HEIGHT:  frm_h = cfg_data_i;
          REG_BORDER_WIDTH:  border = cfg_data_i[7:0];
          REG_CORNER_RADIUS: radius = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no result awaited");
          fail_count_o++;
        end else begin
          e = awaited_results.pop_front();
          compare_field("status", e.status, status_i);
          compare_field("pixel_valid", e.pixel_valid, pixel_valid_i);
          compare_field("out_pixel", e.out_pixel, out_pixel_i);
          compare_field("target_index", e.target_index, target_index_i);
          compare_field("fetch_valid", e.fetch_valid, fetch_valid_i);
          compare_field("fetch_index", e.fetch_index, fetch_index_i);
          compare_field("frame_done", e.frame_done, frame_done_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_results.push_back(predict_item(operation_i, source_pixel_i));
    end
  end

endmodule

[sim/tb_cover_crop_rounded_corner_compositor.sv]
module tb_cover_crop_rounded_corner_compositor;
  import ccrc_pkg::*;

  localparam int ITEM_TARGET = 1950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OP_START;
  logic [15:0] source_pixel_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        pixel_valid_o;
  logic [15:0] out_pixel_o;
  logic [23:0] target_index_o;
  logic        fetch_valid_o;
  logic [23:0] fetch_index_o;
  logic        frame_done_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  int          fail_count;
  int          awaited_count;

  // stimulus side copies of the registers, used to size frames
  int unsigned s_w = 1, s_h = 1, f_w = 1, f_h = 1, brd = 0, rad = 22;
  int          items_sent = 0;
  int          burst_left = 0;
  logic        hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  cover_crop_rounded_corner_compositor u_top (.*);

  ccrc_result_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i,
    .source_pixel_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .pixel_valid_i(pixel_valid_o), .out_pixel_i(out_pixel_o),
    .target_index_i(target_index_o), .fetch_valid_i(fetch_valid_o),
    .fetch_index_i(fetch_index_o), .frame_done_i(frame_done_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .awaited_count_o(awaited_count)
  );

  // one input transfer, with bursts and random gaps
  task automatic send_item(logic op, logic [15:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 25) : 0;
      if (gap > 0) begin
        @(negedge clk_i) in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    source_pixel_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  function automatic logic [15:0] any_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // sender pauses until every result is back
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    burst_left = 0;
    wait (awaited_count == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 13'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  s_w = val & 13'h1FFF;
      REG_SOURCE_HEIGHT: s_h = val & 13'h1FFF;
      REG_FRAME_WIDTH:   f_w = val & 13'h1FFF;
      REG_FRAME_HEIGHT:  f_h = val & 13'h1FFF;
      REG_BORDER_WIDTH:  brd = val & 8'hFF;
      REG_CORNER_RADIUS: rad = val & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned fw,
                              int unsigned fh, int unsigned b, int unsigned r);
    cfg_write(REG_SOURCE_WIDTH, sw);
    cfg_write(REG_SOURCE_HEIGHT, sh);
    cfg_write(REG_FRAME_WIDTH, fw);
    cfg_write(REG_FRAME_HEIGHT, fh);
    cfg_write(REG_BORDER_WIDTH, b);
    cfg_write(REG_CORNER_RADIUS, r);
  endtask

  // one start followed by the image pixels, or only part of them
  task automatic run_frame(bit cut_short);
    int n;
    n = (f_w > 2 * brd && f_h > 2 * brd) ? (f_w - 2 * brd) * (f_h - 2 * brd) : 3;
    if (n > 400) n = 400;
    if (cut_short) n = $urandom_range(0, n);
    send_item(OP_START, any_pixel());
    repeat (n) send_item(OP_PIXEL, any_pixel());
  endtask

  task automatic random_phase();
    int kind, iw, ih, b;
    kind = $urandom_range(0, 9);
    drain();
    if (kind == 0) begin
      // large geometry, only the first pixels of the frame
      set_geometry($urandom_range(1, 4096), $urandom_range(1, 4096),
                   $urandom_range(1, 4096), $urandom_range(1, 4096),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      send_item(OP_START, any_pixel());
      repeat ($urandom_range(1, 12)) send_item(OP_PIXEL, any_pixel());
    end else if (kind == 1) begin
      // malformed geometry
      set_geometry($urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      send_item(OP_START, any_pixel());
      send_item(OP_PIXEL, any_pixel());
    end else begin
      // small image, mostly complete frames, some cut short
      b = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 3);
      iw = $urandom_range(1, 9);
      ih = $urandom_range(1, 9);
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_SOURCE_WIDTH, $urandom_range(1, 16));
        cfg_write(REG_SOURCE_HEIGHT, $urandom_range(1, 16));
      end else begin
        cfg_write(REG_SOURCE_WIDTH, $urandom_range(1, 4096));
        cfg_write(REG_SOURCE_HEIGHT, $urandom_range(1, 4096));
      end
      cfg_write(REG_FRAME_WIDTH, iw + 2 * b);
      cfg_write(REG_FRAME_HEIGHT, ih + 2 * b);
      cfg_write(REG_BORDER_WIDTH, b);
      cfg_write(REG_CORNER_RADIUS,
                ($urandom_range(0, 7) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) send_item(OP_PIXEL, any_pixel());
        run_frame($urandom_range(0, 7) == 0);
      end
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, cyc;
    bit held;
    mode = 0;
    cyc = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (1500) @(negedge clk_i);
      end
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= cyc[0];
      endcase
    end
  end

  initial begin
    #(4 * 6_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: stray pixel, small frame with corners, bad geometries
    send_item(OP_PIXEL, 16'hFFFF);
    drain();
    cfg_write(3'd7, 13'h1FFF);
    set_geometry(4, 4, 6, 6, 1, 1);
    run_frame(1'b0);
    drain();
    cfg_write(REG_FRAME_HEIGHT, 2);
    send_item(OP_START, 16'h0000);
    drain();
    set_geometry(1, 1, 3, 6, 1, 0);
    send_item(OP_START, 16'h0000);
    send_item(OP_PIXEL, 16'h0000);
    drain();
    set_geometry(4096, 4096, 8191, 4096, 255, 255);
    send_item(OP_START, 16'h0000);
    drain();
    cfg_write(REG_FRAME_WIDTH, 4096);
    send_item(OP_START, 16'h0000);
    send_item(OP_PIXEL, 16'h5A5A);

    // random phases
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > 800) hold_req <= 1'b1;
      random_phase();
    end

    drain();
    repeat (400) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[cover_crop_rounded_corner_compositor.f]
src/ccrc_pkg.sv
src/cover_crop_rounded_corner_compositor.sv
src/ccrc_checker.sv
sim/ccrc_result_checker.sv
sim/tb_cover_crop_rounded_corner_compositor.sv
